### design/mctt_pkg.sv
`timescale 1ns / 1ps

package mctt_pkg;

    localparam int OP_W   = 2;
    localparam int KIND_W = 2;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUIET  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_REPLY,
        ST_TICK_RD,
        ST_TICK_EX,
        ST_TICK_END
    } state_t;

endpackage

### design/multi_channel_tick_timer_table.sv
`timescale 1ns / 1ps

// channel   dir   signals                                                   beat
// in        in    in_valid in_ready operation interval_ticks repeat_mode    one add, delete
//                 user_tag target_id                                        or tick
// out       out   out_valid out_ready result_kind success result_id         one reply or
//                 tag_out last                                              expiry event
// cfg       in    cfg_valid cfg_ready cfg_data                              capacity_in_use
//
// sequencing: delete goes straight to its reply; add is refused up front or scans
//   slots from the first until a free slot or the last one, then replies;
//   tick visits every slot, with one slot read per used slot and one pass of the
//   shared increment/compare over the slot memory, then sends its final beat.
// reset: rst_n clears the used bits, the active count and the capacity register
//   (to 16); no clearing pass, the block takes an item right after reset.
// stalls: in_ready is high only between items; the walk holds while an expiry
//   waits behind a full output register, cfg_ready is always high.
module multi_channel_tick_timer_table
    import mctt_pkg::*;
#(
    parameter int NUM_SLOTS     = 16,
    parameter int INTERVAL_BITS = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          operation,
    input  logic [INTERVAL_BITS-1:0] interval_ticks,
    input  logic                     repeat_mode,
    input  logic [31:0]              user_tag,
    input  logic [$clog2(NUM_SLOTS+1)-1:0] target_id,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [KIND_W-1:0]        result_kind,
    output logic                     success,
    output logic [$clog2(NUM_SLOTS+1)-1:0] result_id,
    output logic [31:0]              tag_out,
    output logic                     last,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         cfg_data
);

    localparam int ID_W  = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CMP_W = (ID_W > CAP_W) ? ID_W : CAP_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

    state_t state_reg, state_next;

    logic [CAP_W-1:0]         cap_reg;
    logic [ID_W-1:0]          cnt_reg, cnt_next;
    logic [NUM_SLOTS-1:0]     used_reg, used_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;

    logic [OP_W-1:0]          op_reg;
    logic [INTERVAL_BITS-1:0] iv_reg;
    logic                     rep_reg;
    logic [31:0]              tag_reg;
    logic                     capture;

    logic                     res_ok_reg, res_ok_next;
    logic [ID_W-1:0]          res_id_reg, res_id_next;

    logic                     pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]          pend_id_reg, pend_id_next;
    logic [31:0]              pend_tag_reg, pend_tag_next;

    logic                     out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]        out_kind_reg, out_kind_next;
    logic                     out_ok_reg, out_ok_next;
    logic [ID_W-1:0]          out_id_reg, out_id_next;
    logic [31:0]              out_tag_reg, out_tag_next;
    logic                     out_last_reg, out_last_next;

    // slot memories, one address per cycle (idx_reg), registered read
    logic [INTERVAL_BITS-1:0] iv_mem  [NUM_SLOTS];
    logic [INTERVAL_BITS-1:0] el_mem  [NUM_SLOTS];
    logic                     rep_mem [NUM_SLOTS];
    logic [31:0]              tag_mem [NUM_SLOTS];

    logic [INTERVAL_BITS-1:0] rd_iv_reg;
    logic [INTERVAL_BITS-1:0] rd_el_reg;
    logic                     rd_rep_reg;
    logic [31:0]              rd_tag_reg;

    logic                     add_we;
    logic                     el_we;
    logic [INTERVAL_BITS-1:0] el_wdata;
    logic                     rd_en;

    logic                     out_free;
    logic                     add_ok;
    logic                     del_hit;
    logic [ID_W-1:0]          del_sub;
    logic [IDX_W-1:0]         del_idx;
    logic [INTERVAL_BITS-1:0] el_inc;
    logic                     expire;
    logic [ID_W-1:0]          idx_id;

    assign out_free = !out_valid_reg || out_ready;
    assign add_ok   = (interval_ticks != '0) && (CMP_W'(cnt_reg) < CMP_W'(cap_reg));
    assign del_sub  = target_id - ID_W'(1);
    assign del_idx  = del_sub[IDX_W-1:0];
    assign del_hit  = (target_id != '0) && (target_id <= ID_W'(NUM_SLOTS)) && used_reg[del_idx];
    assign el_inc   = rd_el_reg + INTERVAL_BITS'(1);
    assign expire   = (el_inc == rd_iv_reg);
    assign idx_id   = ID_W'(idx_reg) + ID_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (operation)
                        OP_ADD:  state_next = add_ok ? ST_ADD_SCAN : ST_REPLY;
                        OP_DEL:  state_next = ST_REPLY;
                        OP_TICK: state_next = ST_TICK_RD;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_SCAN:
            begin
                if (!used_reg[idx_reg] || idx_reg == IDX_LAST)
                    state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_TICK_RD:
            begin
                if (used_reg[idx_reg])
                    state_next = ST_TICK_EX;
                else if (idx_reg == IDX_LAST)
                    state_next = ST_TICK_END;
            end
            ST_TICK_EX:
            begin
                if (!(expire && pend_valid_reg && !out_free))
                    state_next = (idx_reg == IDX_LAST) ? ST_TICK_END : ST_TICK_RD;
            end
            ST_TICK_END:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        used_next       = used_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        capture         = 1'b0;
        res_ok_next     = res_ok_reg;
        res_id_next     = res_id_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_tag_next   = pend_tag_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_ok_next     = out_ok_reg;
        out_id_next     = out_id_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        add_we          = 1'b0;
        el_we           = 1'b0;
        el_wdata        = '0;
        rd_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    capture         = 1'b1;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    res_ok_next     = 1'b0;
                    res_id_next     = '0;
                    if (operation == OP_DEL && del_hit)
                    begin
                        used_next[del_idx] = 1'b0;
                        res_ok_next        = 1'b1;
                        if (cnt_reg != '0)
                            cnt_next = cnt_reg - ID_W'(1);
                    end
                end
            end
            ST_ADD_SCAN:
            begin
                if (!used_reg[idx_reg])
                begin
                    add_we             = 1'b1;
                    el_we              = 1'b1;
                    el_wdata           = '0;
                    used_next[idx_reg] = 1'b1;
                    cnt_next           = cnt_reg + ID_W'(1);
                    res_ok_next        = 1'b1;
                    res_id_next        = idx_id;
                end
                else if (idx_reg != IDX_LAST)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = (op_reg == OP_ADD) ? KIND_ADD : KIND_DEL;
                    out_ok_next    = res_ok_reg;
                    out_id_next    = res_id_reg;
                    out_tag_next   = '0;
                    out_last_next  = 1'b1;
                end
            end
            ST_TICK_RD:
            begin
                if (used_reg[idx_reg])
                    rd_en = 1'b1;
                else if (idx_reg != IDX_LAST)
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_TICK_EX:
            begin
                if (!expire)
                begin
                    el_we    = 1'b1;
                    el_wdata = el_inc;
                    if (idx_reg != IDX_LAST)
                        idx_next = idx_reg + IDX_W'(1);
                end
                else if (!(pend_valid_reg && !out_free))
                begin
                    // the held expiry is not the final one, send it on
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_EXPIRY;
                        out_ok_next    = 1'b0;
                        out_id_next    = pend_id_reg;
                        out_tag_next   = pend_tag_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = idx_id;
                    pend_tag_next   = rd_tag_reg;
                    el_we           = 1'b1;
                    el_wdata        = '0;
                    if (!rd_rep_reg)
                    begin
                        used_next[idx_reg] = 1'b0;
                        if (cnt_reg != '0)
                            cnt_next = cnt_reg - ID_W'(1);
                    end
                    if (idx_reg != IDX_LAST)
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_TICK_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = 1'b0;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_kind_next = KIND_EXPIRY;
                        out_id_next   = pend_id_reg;
                        out_tag_next  = pend_tag_reg;
                    end
                    else
                    begin
                        out_kind_next = KIND_QUIET;
                        out_id_next   = '0;
                        out_tag_next  = '0;
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAP_RESET;
            cnt_reg        <= '0;
            used_reg       <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            used_reg       <= used_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            op_reg  <= operation;
            iv_reg  <= interval_ticks;
            rep_reg <= repeat_mode;
            tag_reg <= user_tag;
        end
        res_ok_reg   <= res_ok_next;
        res_id_reg   <= res_id_next;
        pend_id_reg  <= pend_id_next;
        pend_tag_reg <= pend_tag_next;
        out_kind_reg <= out_kind_next;
        out_ok_reg   <= out_ok_next;
        out_id_reg   <= out_id_next;
        out_tag_reg  <= out_tag_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (add_we)
        begin
            iv_mem[idx_reg]  <= iv_reg;
            rep_mem[idx_reg] <= rep_reg;
            tag_mem[idx_reg] <= tag_reg;
        end
        if (el_we)
            el_mem[idx_reg] <= el_wdata;
        if (rd_en)
        begin
            rd_iv_reg  <= iv_mem[idx_reg];
            rd_el_reg  <= el_mem[idx_reg];
            rd_rep_reg <= rep_mem[idx_reg];
            rd_tag_reg <= tag_mem[idx_reg];
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign success     = out_ok_reg;
    assign result_id   = out_id_reg;
    assign tag_out     = out_tag_reg;
    assign last        = out_last_reg;

endmodule

### tb/sv/multi_channel_tick_timer_table_tb.sv
`timescale 1ns / 1ps

module multi_channel_tick_timer_table_tb;
    import mctt_pkg::*;

    localparam int NUM_SLOTS     = 16;
    localparam int INTERVAL_BITS = 24;
    localparam int ID_W          = $clog2(NUM_SLOTS + 1);

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 48;
    localparam int NUM_PHASES     = 6;
    localparam int NUM_DIRECTED   = 23;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [INTERVAL_BITS-1:0] period;
        logic                     periodic;
        logic [31:0]              tag;
        logic [ID_W-1:0]          tid;
    } timer_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              ok;
        logic [ID_W-1:0]   id;
        logic [31:0]       tag;
        logic              fin;
    } timer_beat_t;

    // reply known up front; known == 0 means take it from the predictor
    typedef struct packed {
        logic              known;
        logic [KIND_W-1:0] kind;
        logic              ok;
        logic [ID_W-1:0]   id;
    } fixed_reply_t;

    typedef struct packed {
        timer_item_t  stim;
        fixed_reply_t reply;
    } directed_row_t;

    localparam fixed_reply_t BY_MODEL    = '0;
    localparam fixed_reply_t QUIET_TICK  = {1'b1, KIND_QUIET, 1'b0, 5'd0};
    localparam fixed_reply_t ADD_REFUSED = {1'b1, KIND_ADD, 1'b0, 5'd0};
    localparam fixed_reply_t DEL_REFUSED = {1'b1, KIND_DEL, 1'b0, 5'd0};
    localparam fixed_reply_t DEL_DONE    = {1'b1, KIND_DEL, 1'b1, 5'd0};

    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        {{OP_TICK,    24'h000000, 1'b0, 32'h0000_0000, 5'd0},  QUIET_TICK},
        // zero interval
        {{OP_ADD,     24'h000000, 1'b1, 32'hFFFF_FFFF, 5'd31}, ADD_REFUSED},
        // id zero, id above the table, unused slot
        {{OP_DEL,     24'hFFFFFF, 1'b1, 32'hFFFF_FFFF, 5'd0},  DEL_REFUSED},
        {{OP_DEL,     24'h000000, 1'b0, 32'h0000_0000, 5'd31}, DEL_REFUSED},
        {{OP_DEL,     24'h000000, 1'b0, 32'h0000_0000, 5'd17}, DEL_REFUSED},
        {{OP_DEL,     24'h000000, 1'b0, 32'h0000_0000, 5'd16}, DEL_REFUSED},
        {{OP_ADD,     24'h000001, 1'b0, 32'hFFFF_FFFF, 5'd0},  {1'b1, KIND_ADD, 1'b1, 5'd1}},
        {{OP_ADD,     24'hFFFFFF, 1'b1, 32'h0000_0000, 5'd31}, {1'b1, KIND_ADD, 1'b1, 5'd2}},
        {{OP_ADD,     24'h000002, 1'b1, 32'hA5A5_5A5A, 5'd0},  {1'b1, KIND_ADD, 1'b1, 5'd3}},
        {{OP_TICK,    24'hFFFFFF, 1'b1, 32'hFFFF_FFFF, 5'd31}, BY_MODEL},
        // ignored operation, no beat
        {{OP_IGNORED, 24'hFFFFFF, 1'b1, 32'hFFFF_FFFF, 5'd31}, BY_MODEL},
        {{OP_TICK,    24'h000000, 1'b0, 32'h0000_0000, 5'd0},  BY_MODEL},
        // one-shot already gone
        {{OP_DEL,     24'h000000, 1'b0, 32'h0000_0000, 5'd1},  DEL_REFUSED},
        {{OP_ADD,     24'h000003, 1'b0, 32'h0000_1234, 5'd0},  {1'b1, KIND_ADD, 1'b1, 5'd1}},
        {{OP_DEL,     24'h000000, 1'b0, 32'h0000_0000, 5'd2},  DEL_DONE},
        {{OP_TICK,    24'h000000, 1'b0, 32'h0000_0000, 5'd0},  BY_MODEL},
        {{OP_TICK,    24'h000000, 1'b0, 32'h0000_0000, 5'd0},  BY_MODEL},
        {{OP_TICK,    24'h000000, 1'b0, 32'h0000_0000, 5'd0},  BY_MODEL},
        {{OP_ADD,     24'h000001, 1'b1, 32'h8000_0001, 5'd0},  BY_MODEL},
        {{OP_ADD,     24'h000001, 1'b1, 32'h7FFF_FFFE, 5'd0},  BY_MODEL},
        {{OP_TICK,    24'h000000, 1'b0, 32'h0000_0000, 5'd0},  BY_MODEL},
        {{OP_DEL,     24'h000000, 1'b0, 32'h0000_0000, 5'd3},  BY_MODEL},
        {{OP_TICK,    24'h000000, 1'b0, 32'h0000_0000, 5'd0},  BY_MODEL}
    };

    localparam int PHASE_ADD_PCT  [NUM_PHASES] = '{35, 30, 70, 45, 45, 45};
    localparam int PHASE_IDLE_PCT [NUM_PHASES] = '{25, 0, 20, 30, 20, 0};

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [OP_W-1:0]          operation;
    logic [INTERVAL_BITS-1:0] interval_ticks;
    logic                     repeat_mode;
    logic [31:0]              user_tag;
    logic [ID_W-1:0]          target_id;
    logic                     out_valid;
    logic                     out_ready;
    logic [KIND_W-1:0]        result_kind;
    logic                     success;
    logic [ID_W-1:0]          result_id;
    logic [31:0]              tag_out;
    logic                     last;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_data;

    // predictor copy of the timer table
    bit                       slot_busy       [NUM_SLOTS];
    logic [INTERVAL_BITS-1:0] slot_period     [NUM_SLOTS];
    logic [INTERVAL_BITS-1:0] slot_count      [NUM_SLOTS];
    bit                       slot_periodic   [NUM_SLOTS];
    logic [31:0]              slot_owner_tag  [NUM_SLOTS];
    int                       live_timers;
    logic [CAP_W-1:0]         cap_limit;

    timer_beat_t step_beats[$];
    timer_beat_t expected_results[$];

    int error_count;
    int cycle_count;
    int idle_pct;
    bit hold_off_req;

    multi_channel_tick_timer_table #(
        .NUM_SLOTS     (NUM_SLOTS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .interval_ticks (interval_ticks),
        .repeat_mode    (repeat_mode),
        .user_tag       (user_tag),
        .target_id      (target_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .success        (success),
        .result_id      (result_id),
        .tag_out        (tag_out),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // work out the beats one accepted item causes and update the table copy
    function automatic void apply_timer_op(input timer_item_t it);
        int              s;
        bit              placed;
        logic [ID_W-1:0] slot_id;
        step_beats.delete();
        placed = 1'b0;
        case (it.op)
            OP_ADD:
            begin
                if (it.period != 0 && live_timers < cap_limit)
                begin
                    for (s = 0; s < NUM_SLOTS; s++)
                    begin
                        if (!placed && !slot_busy[s])
                        begin
                            placed            = 1'b1;
                            slot_busy[s]      = 1'b1;
                            slot_period[s]    = it.period;
                            slot_count[s]     = '0;
                            slot_periodic[s]  = it.periodic;
                            slot_owner_tag[s] = it.tag;
                            live_timers++;
                            slot_id = ID_W'(s + 1);
                            step_beats.push_back({KIND_ADD, 1'b1, slot_id, 32'd0, 1'b1});
                        end
                    end
                end
                if (!placed)
                    step_beats.push_back({KIND_ADD, 1'b0, {ID_W{1'b0}}, 32'd0, 1'b1});
            end
            OP_DEL:
            begin
                if (it.tid >= 1 && it.tid <= NUM_SLOTS && slot_busy[it.tid - 1])
                begin
                    slot_busy[it.tid - 1]  = 1'b0;
                    slot_count[it.tid - 1] = '0;
                    if (live_timers > 0)
                        live_timers--;
                    placed = 1'b1;
                end
                step_beats.push_back({KIND_DEL, placed, {ID_W{1'b0}}, 32'd0, 1'b1});
            end
            OP_TICK:
            begin
                for (s = 0; s < NUM_SLOTS; s++)
                begin
                    if (slot_busy[s])
                    begin
                        slot_count[s] = slot_count[s] + 1'b1;
                        if (slot_count[s] == slot_period[s])
                        begin
                            slot_id = ID_W'(s + 1);
                            step_beats.push_back({KIND_EXPIRY, 1'b0, slot_id,
                                                  slot_owner_tag[s], 1'b0});
                            slot_count[s] = '0;
                            if (!slot_periodic[s])
                            begin
                                slot_busy[s] = 1'b0;
                                if (live_timers > 0)
                                    live_timers--;
                            end
                        end
                    end
                end
                if (step_beats.size() == 0)
                    step_beats.push_back({KIND_QUIET, 1'b0, {ID_W{1'b0}}, 32'd0, 1'b1});
                else
                    step_beats[step_beats.size() - 1].fin = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic timer_item_t random_timer_item(input int add_pct);
        timer_item_t it;
        int          pick;
        int          busy_ids[$];
        it.op       = OP_TICK;
        it.period   = INTERVAL_BITS'($urandom());
        it.periodic = 1'($urandom_range(0, 1));
        it.tag      = $urandom();
        it.tid      = ID_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < add_pct)
        begin
            it.op = OP_ADD;
            case ($urandom_range(0, 19))
                0:       it.period = '0;
                1, 2:    it.period = INTERVAL_BITS'($urandom());
                3, 4, 5: it.period = INTERVAL_BITS'($urandom_range(1, 40));
                default: it.period = INTERVAL_BITS'($urandom_range(1, 6));
            endcase
        end
        else if (pick < add_pct + (100 - add_pct) / 3)
        begin
            it.op = OP_DEL;
            for (int s = 0; s < NUM_SLOTS; s++)
                if (slot_busy[s])
                    busy_ids.push_back(s + 1);
            if (busy_ids.size() != 0 && $urandom_range(0, 9) < 7)
                it.tid = ID_W'(busy_ids[$urandom_range(0, busy_ids.size() - 1)]);
        end
        else if (pick >= 98)
        begin
            it.op = OP_IGNORED;
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_item(input timer_item_t it, input fixed_reply_t reply);
        @(negedge clk);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        {operation, interval_ticks, repeat_mode, user_tag, target_id} = it;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        apply_timer_op(it);
        if (reply.known)
            expected_results.push_back({reply.kind, reply.ok, reply.id, 32'd0, 1'b1});
        else
            foreach (step_beats[k])
                expected_results.push_back(step_beats[k]);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        pause_until_drained();
        // extra margin before the write; a walk ends when it sends its final beat
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cap_limit = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready    = 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++)
                    @(negedge clk);
            end
            else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        timer_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with none expected: kind %0d id %0d tag %0h",
                       result_kind, result_id, tag_out);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(result_kind));
                check_field("success", 32'(want.ok), 32'(success));
                check_field("result_id", 32'(want.id), 32'(result_id));
                check_field("tag_out", want.tag, tag_out);
                check_field("last", 32'(want.fin), 32'(last));
            end
        end
    end

    initial
    begin
        logic [CAP_W-1:0] cap;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = OP_ADD;
        interval_ticks = '0;
        repeat_mode    = 1'b0;
        user_tag       = '0;
        target_id      = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        error_count    = 0;
        cycle_count    = 0;
        idle_pct       = 20;
        hold_off_req   = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++)
            slot_busy[s] = 1'b0;
        live_timers = 0;
        cap_limit   = CAP_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_ROWS[r])
            send_item(DIRECTED_ROWS[r].stim, DIRECTED_ROWS[r].reply);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       cap = 5'd1;
                1:       cap = 5'd0;
                2:       cap = 5'd31;
                3:       cap = 5'd4;
                4:       cap = CAP_W'($urandom_range(1, 16));
                default: cap = CAP_RESET;
            endcase
            write_capacity(cap);
            idle_pct = PHASE_IDLE_PCT[p];
            // fill the block up behind a stalled output
            if (p == 2)
                hold_off_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 3 && n == PHASE_ITEMS / 2)
                    pause_until_drained();
                send_item(random_timer_item(PHASE_ADD_PCT[p]), BY_MODEL);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && expected_results.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected result beats never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
